/* rtl/pbkdf_pkg.sv */
// Package for the PBKDF2 HMAC-SHA1 engine: shared types and constants.
// No dependencies.
`timescale 1ns / 1ps
package pbkdf_pkg;

  // Store sizes.
  localparam int PASSWORD_MAX = 64;
  localparam int SALT_MAX     = 64;

  localparam logic [1:0] MODE_PASSWORD = 2'd0;
  localparam logic [1:0] MODE_SALT     = 2'd1;
  localparam logic [1:0] MODE_START    = 2'd2;
  localparam logic [1:0] MODE_RSVD     = 2'd3; // unused, dropped

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_PASS_LONG = 2'd1;
  localparam logic [1:0] STATUS_SALT_LONG = 2'd2;

  localparam logic [0:0] CFG_ITER = 1'b0;
  localparam logic [0:0] CFG_KLEN = 1'b1;

  // Controller to datapath commands.
  typedef struct packed {
    logic       init_chain;   // load SHA-1 initial value
    logic       start_comp;   // begin one 80-round compression
    logic [3:0] blk_kind;     // which message block to build
    logic       save_inner;   // keep digest as inner hash
    logic       save_u_first; // digest is U1: load prev and acc
    logic       save_u_next;  // digest is Uj: load prev, xor acc
  } pbkdf_cmd_t;

  typedef struct packed {
    logic comp_busy;
  } pbkdf_sts_t;

  // Message block kinds.
  localparam logic [3:0] BLK_IPAD   = 4'd0;
  localparam logic [3:0] BLK_OPAD   = 4'd1;
  localparam logic [3:0] BLK_SALT0  = 4'd2; // first data block after ipad
  localparam logic [3:0] BLK_SALT1  = 4'd3; // second data block
  localparam logic [3:0] BLK_UMSG   = 4'd4; // prev U + padding (len 84)
  localparam logic [3:0] BLK_INNER  = 4'd5; // inner hash + padding (len 84)

  function automatic logic [31:0] rotl(input logic [31:0] v, input int n);
    rotl = (v << n) | (v >> (32 - n));
  endfunction

endpackage

/* rtl/pbkdf_ram.sv */
// Generic single-port-write RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module pbkdf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

/* rtl/pbkdf_datapath.sv */
// Datapath: password/salt stores, block builder, SHA-1 round unit, U and
// accumulator registers. Depends on pbkdf_pkg and pbkdf_ram.
`timescale 1ns / 1ps
module pbkdf_datapath
  import pbkdf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        pw_we,
  input  logic [5:0]  pw_waddr,
  input  logic        salt_we,
  input  logic [$clog2(SALT_MAX)-1:0] salt_waddr,
  input  logic [7:0]  wbyte,
  input  logic [6:0]  pw_count,
  input  logic [$clog2(SALT_MAX+1)-1:0] salt_count,
  input  logic [2:0]  block_num,
  input  pbkdf_cmd_t  cmd,
  output pbkdf_sts_t  sts,
  input  logic [4:0]  out_sel,
  output logic [7:0]  out_byte
);
  localparam int SAW = $clog2(SALT_MAX);

  // Byte stores. Read address is the byte position of the next fill step.
  logic [5:0]     pw_raddr;
  logic [SAW-1:0] salt_raddr;
  logic [7:0]     pw_rdata, salt_rdata;

  pbkdf_ram #(.WIDTH(8), .DEPTH(PASSWORD_MAX)) u_pw (
    .clk(clk), .we(pw_we), .waddr(pw_waddr), .wdata(wbyte),
    .raddr(pw_raddr), .rdata(pw_rdata));
  pbkdf_ram #(.WIDTH(8), .DEPTH(SALT_MAX)) u_salt (
    .clk(clk), .we(salt_we), .waddr(salt_waddr), .wdata(wbyte),
    .raddr(salt_raddr), .rdata(salt_rdata));

  // Message schedule window, hash state, working vars.
  logic [31:0] w_r [16];
  logic [31:0] h_r [5];
  logic [31:0] a_r, b_r, c_r, d_r, e_r;
  logic [31:0] inner_r [5];
  logic [31:0] prev_r  [5];
  logic [31:0] acc_r   [5];

  // Fill sequencer: 64 byte steps (pipelined read), then 80 rounds, then add.
  logic [1:0]  phase_r;        // 0 idle, 1 fill, 2 rounds, 3 add
  logic [6:0]  cnt_r;          // fill byte index (0..64) or round index
  logic [3:0]  kind_r;
  logic        fill_v_r;       // byte of pipeline valid
  logic [5:0]  fill_pos_r;
  logic [1:0]  fill_src_r;     // 0 const, 1 pw, 2 salt
  logic [7:0]  fill_const_r;
  logic [31:0] bytes_r;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_FILL = 2'd1;
  localparam logic [1:0] PH_RND  = 2'd2;
  localparam logic [1:0] PH_ADD  = 2'd3;

  assign sts.comp_busy = (phase_r != PH_IDLE);

  // Byte value of block byte p of the current kind (combinational decode).
  logic [1:0]  src_c;
  logic [7:0]  const_c;
  logic [SAW+1:0] sidx_c;
  logic [8:0]  total_len;
  logic [15:0] bitlen;
  logic [7:0]  dig_byte;
  logic [8:0]  lpos;
  always_comb begin
    src_c   = 2'd0;
    const_c = 8'h00;
    sidx_c  = '0;
    pw_raddr = cnt_r[5:0];
    total_len = 9'd64 + 9'(salt_count) + 9'd4;
    bitlen  = 16'd0;
    dig_byte = 8'h00;
    lpos = 9'd0;
    case (kind_r)
      BLK_IPAD, BLK_OPAD: begin
        const_c = (kind_r == BLK_IPAD) ? 8'h36 : 8'h5C;
        src_c = (7'(cnt_r[5:0]) < pw_count) ? 2'd1 : 2'd0;
      end
      BLK_SALT0, BLK_SALT1: begin
        lpos = (kind_r == BLK_SALT1) ? 9'd64 + 9'(cnt_r[5:0]) : 9'(cnt_r[5:0]);
        bitlen = 16'(total_len) << 3;
        sidx_c = (SAW+2)'(lpos);
        if (lpos < 9'(salt_count)) src_c = 2'd2;
        else if (lpos < 9'(salt_count) + 9'd3) const_c = 8'h00;
        else if (lpos == 9'(salt_count) + 9'd3) const_c = {5'd0, block_num};
        else if (lpos == 9'(salt_count) + 9'd4) const_c = 8'h80;
        else if (lpos >= 9'd62 && kind_r == BLK_SALT0 && total_len - 9'd64 < 9'd56)
          const_c = (lpos == 9'd62) ? bitlen[15:8] : bitlen[7:0];
        else if (lpos >= 9'd126)
          const_c = (lpos == 9'd126) ? bitlen[15:8] : bitlen[7:0];
        else const_c = 8'h00;
      end
      default: begin
        // 20-byte digest then padding for 84-byte total (672 bits).
        if (cnt_r[5:0] < 6'd20) begin
          if (kind_r == BLK_UMSG)
            dig_byte = 8'(prev_r[cnt_r[4:2]] >> (5'd24 - {cnt_r[1:0], 3'b000}));
          else
            dig_byte = 8'(inner_r[cnt_r[4:2]] >> (5'd24 - {cnt_r[1:0], 3'b000}));
          const_c = dig_byte;
        end else if (cnt_r[5:0] == 6'd20) const_c = 8'h80;
        else if (cnt_r[5:0] == 6'd62) const_c = 8'h02;
        else if (cnt_r[5:0] == 6'd63) const_c = 8'hA0;
        else const_c = 8'h00;
      end
    endcase
    salt_raddr = sidx_c[SAW-1:0];
  end

  logic [7:0] fbyte;
  always_comb begin
    case (fill_src_r)
      2'd1:    fbyte = pw_rdata ^ fill_const_r;
      2'd2:    fbyte = salt_rdata;
      default: fbyte = fill_const_r;
    endcase
  end

  // SHA-1 round logic.
  logic [6:0]  t;
  logic [31:0] wt, f, k, tmp;
  assign t = cnt_r;
  always_comb begin
    if (t < 7'd16) wt = w_r[t[3:0]];
    else wt = rotl(w_r[4'(t - 7'd3)] ^ w_r[4'(t - 7'd8)] ^
                   w_r[4'(t - 7'd14)] ^ w_r[t[3:0]], 1);
    if (t < 7'd20) begin
      f = (b_r & c_r) | (~b_r & d_r); k = 32'h5A827999;
    end else if (t < 7'd40) begin
      f = b_r ^ c_r ^ d_r; k = 32'h6ED9EBA1;
    end else if (t < 7'd60) begin
      f = (b_r & c_r) | (b_r & d_r) | (c_r & d_r); k = 32'h8F1BBCDC;
    end else begin
      f = b_r ^ c_r ^ d_r; k = 32'hCA62C1D6;
    end
    tmp = rotl(a_r, 5) + f + e_r + k + wt;
  end

  // Sequencer and registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      cnt_r    <= '0;
      kind_r   <= BLK_IPAD;
      fill_v_r <= 1'b0;
    end else begin
      if (cmd.init_chain) begin
        h_r[0] <= 32'h67452301; h_r[1] <= 32'hEFCDAB89; h_r[2] <= 32'h98BADCFE;
        h_r[3] <= 32'h10325476; h_r[4] <= 32'hC3D2E1F0;
      end
      // Registered byte pipeline lands into the word window.
      if (fill_v_r) begin
        bytes_r <= {bytes_r[23:0], fbyte};
        if (fill_pos_r[1:0] == 2'd3) w_r[fill_pos_r[5:2]] <= {bytes_r[23:0], fbyte};
      end
      case (phase_r)
        PH_IDLE: begin
          fill_v_r <= 1'b0;
          if (cmd.start_comp) begin
            phase_r <= PH_FILL;
            kind_r  <= cmd.blk_kind;
            cnt_r   <= '0;
          end
        end
        PH_FILL: begin
          fill_v_r     <= (cnt_r < 7'd64);
          fill_pos_r   <= cnt_r[5:0];
          fill_src_r   <= src_c;
          fill_const_r <= const_c;
          if (cnt_r == 7'd64) begin
            phase_r <= PH_RND;
            cnt_r   <= '0;
            a_r <= h_r[0]; b_r <= h_r[1]; c_r <= h_r[2]; d_r <= h_r[3]; e_r <= h_r[4];
          end else cnt_r <= cnt_r + 7'd1;
        end
        PH_RND: begin
          fill_v_r <= 1'b0;
          w_r[t[3:0]] <= wt;
          e_r <= d_r; d_r <= c_r; c_r <= rotl(b_r, 30); b_r <= a_r; a_r <= tmp;
          if (cnt_r == 7'd79) phase_r <= PH_ADD;
          cnt_r <= cnt_r + 7'd1;
        end
        default: begin
          h_r[0] <= h_r[0] + a_r; h_r[1] <= h_r[1] + b_r; h_r[2] <= h_r[2] + c_r;
          h_r[3] <= h_r[3] + d_r; h_r[4] <= h_r[4] + e_r;
          phase_r <= PH_IDLE;
        end
      endcase
    end
  end

  // Digest capture.
  always_ff @(posedge clk) begin
    for (int i = 0; i < 5; i++) begin
      if (cmd.save_inner) inner_r[i] <= h_r[i];
      if (cmd.save_u_first) begin
        prev_r[i] <= h_r[i];
        acc_r[i]  <= h_r[i];
      end
      if (cmd.save_u_next) begin
        prev_r[i] <= h_r[i];
        acc_r[i]  <= acc_r[i] ^ h_r[i];
      end
    end
  end

  assign out_byte = 8'(acc_r[out_sel[4:2]] >> (5'd24 - {out_sel[1:0], 3'b000}));

  assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_RND |-> cnt_r < 7'd80)
    else $error("round index out of range");
  assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_RND && cnt_r == 7'd79) |=> phase_r == PH_ADD)
    else $error("missing final add");
  assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_ADD |=> phase_r == PH_IDLE)
    else $error("add not single cycle");
endmodule

/* rtl/pbkdf_ctrl.sv */
// Controller: input handshake, counts, overflow, HMAC/PBKDF2 sequencing
// and key byte output. Depends on pbkdf_pkg.
`timescale 1ns / 1ps
module pbkdf_ctrl
  import pbkdf_pkg::*;
#(
  parameter int KEY_MAX        = 64,
  parameter int ITERATION_BITS = 24
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [1:0]  in_mode,
  input  logic [7:0]  in_byte,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_idx,
  input  logic [23:0] cfg_wdata,
  output logic        pw_we,
  output logic [5:0]  pw_waddr,
  output logic        salt_we,
  output logic [$clog2(SALT_MAX)-1:0] salt_waddr,
  output logic [6:0]  pw_count,
  output logic [$clog2(SALT_MAX+1)-1:0] salt_count,
  output logic [2:0]  block_num,
  output pbkdf_cmd_t  cmd,
  input  pbkdf_sts_t  sts,
  output logic [4:0]  out_sel,
  input  logic [7:0]  out_byte,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_key,
  output logic        out_last,
  output logic [1:0]  out_status
);
  localparam int SCW = $clog2(SALT_MAX+1);

  localparam logic [3:0] S_LOAD  = 4'd0;
  localparam logic [3:0] S_HMAC  = 4'd1;  // issue next compression
  localparam logic [3:0] S_WAIT  = 4'd2;
  localparam logic [3:0] S_EMIT  = 4'd3;
  localparam logic [3:0] S_ERR   = 4'd4;
  localparam logic [3:0] S_GAP   = 4'd5;

  logic [3:0]  state_r;
  logic [23:0] iter_cfg_r;
  logic [6:0]  klen_cfg_r;
  logic [6:0]  pw_cnt_r;
  logic [SCW-1:0] salt_cnt_r;
  logic [1:0]  ovf_r;
  logic [ITERATION_BITS-1:0] iter_r, iter_left_r;
  logic [6:0]  klen_r, n_r;
  logic [2:0]  blk_r;
  logic [4:0]  j_r;
  logic [2:0]  step_r;  // compression step inside HMAC
  logic [2:0]  nsteps;
  logic        first_r; // computing U1
  logic        last_r;
  logic [7:0]  key_r;
  logic [1:0]  stat_r;
  logic        ovalid_r;

  assign pw_count   = pw_cnt_r;
  assign salt_count = salt_cnt_r;
  assign block_num  = blk_r;
  assign out_sel    = j_r;
  assign out_tvalid = ovalid_r;
  assign out_key    = key_r;
  assign out_last   = last_r;
  assign out_status = stat_r;

  logic acc_in;
  assign in_tready = (state_r == S_LOAD) && !ovalid_r;
  assign acc_in    = in_tvalid && in_tready;

  assign pw_we      = acc_in && in_mode == MODE_PASSWORD && pw_cnt_r < 7'(PASSWORD_MAX);
  assign pw_waddr   = pw_cnt_r[5:0];
  assign salt_we    = acc_in && in_mode == MODE_SALT && salt_cnt_r < SCW'(SALT_MAX);
  assign salt_waddr = salt_cnt_r[SCW-2:0];

  // U1 has ipad, salt block(s), opad, inner; later Us have four steps.
  logic two_salt;
  assign two_salt = (7'd64 - 7'(salt_cnt_r) < 7'd9) ||
                    (8'(salt_cnt_r) + 8'd4 >= 8'd56);
  assign nsteps = (first_r && two_salt) ? 3'd5 : 3'd4;

  logic [3:0] kind;
  always_comb begin
    if (step_r == 3'd0) kind = BLK_IPAD;
    else if (step_r == 3'd1) kind = first_r ? BLK_SALT0 : BLK_UMSG;
    else if (step_r == 3'd2 && first_r && two_salt) kind = BLK_SALT1;
    else if (step_r == nsteps - 3'd2) kind = BLK_OPAD;
    else kind = BLK_INNER;
  end

  logic [ITERATION_BITS-1:0] iter_c;
  logic [6:0] klen_c;
  always_comb begin
    iter_c = ITERATION_BITS'(iter_cfg_r);
    if (iter_c == '0) iter_c = ITERATION_BITS'(1);
    klen_c = klen_cfg_r;
    if (klen_c == 7'd0) klen_c = 7'd1;
    if (klen_c > 7'(KEY_MAX)) klen_c = 7'(KEY_MAX);
  end

  always_comb begin
    cmd = '0;
    if (state_r == S_HMAC) begin
      cmd.start_comp = 1'b1;
      cmd.blk_kind   = kind;
      cmd.init_chain = (step_r == 3'd0) || (step_r == nsteps - 3'd2);
    end
    if (state_r == S_WAIT && !sts.comp_busy && step_r == nsteps - 3'd3)
      cmd.save_inner = 1'b1;
    if (state_r == S_WAIT && !sts.comp_busy && step_r == nsteps - 3'd1) begin
      cmd.save_u_first = first_r;
      cmd.save_u_next  = !first_r;
    end
  end

  // Main sequencer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_LOAD;
      iter_cfg_r <= 24'd1;
      klen_cfg_r <= 7'd20;
      pw_cnt_r   <= '0;
      salt_cnt_r <= '0;
      ovf_r      <= 2'b00;
      ovalid_r   <= 1'b0;
      step_r     <= '0;
      first_r    <= 1'b0;
      blk_r      <= '0;
      n_r        <= '0;
      j_r        <= '0;
    end else begin
      if (cfg_we) begin
        if (cfg_idx == CFG_ITER) iter_cfg_r <= cfg_wdata;
        else klen_cfg_r <= cfg_wdata[6:0];
      end
      // Drop the output once taken; the emit state handles its own refill.
      if (ovalid_r && out_tready && state_r != S_EMIT) ovalid_r <= 1'b0;
      case (state_r)
        S_LOAD: begin
          if (acc_in) begin
            if (in_mode == MODE_PASSWORD) begin
              if (pw_cnt_r < 7'(PASSWORD_MAX)) pw_cnt_r <= pw_cnt_r + 7'd1;
              else ovf_r[0] <= 1'b1;
            end else if (in_mode == MODE_SALT) begin
              if (salt_cnt_r < SCW'(SALT_MAX)) salt_cnt_r <= salt_cnt_r + 1'b1;
              else ovf_r[1] <= 1'b1;
            end else if (in_mode == MODE_START) begin
              if (ovf_r != 2'b00) state_r <= S_ERR;
              else begin
                iter_r  <= iter_c;
                klen_r  <= klen_c;
                n_r     <= '0;
                blk_r   <= 3'd1;
                iter_left_r <= iter_c;
                first_r <= 1'b1;
                step_r  <= '0;
                state_r <= S_HMAC;
              end
            end
          end
        end
        S_ERR: begin
          ovalid_r <= 1'b1;
          key_r    <= 8'd0;
          last_r   <= 1'b1;
          stat_r   <= ovf_r[0] ? STATUS_PASS_LONG : STATUS_SALT_LONG;
          pw_cnt_r <= '0; salt_cnt_r <= '0; ovf_r <= 2'b00;
          state_r  <= S_LOAD;
        end
        S_HMAC: state_r <= S_GAP;
        S_GAP:  state_r <= S_WAIT;
        S_WAIT: begin
          if (!sts.comp_busy) begin
            if (step_r == nsteps - 3'd1) begin
              step_r  <= '0;
              first_r <= 1'b0;
              if (iter_left_r > ITERATION_BITS'(1)) begin
                iter_left_r <= iter_left_r - 1'b1;
                state_r <= S_HMAC;
              end else begin
                j_r <= '0;
                state_r <= S_EMIT;
              end
            end else begin
              step_r  <= step_r + 3'd1;
              state_r <= S_HMAC;
            end
          end
        end
        default: begin // S_EMIT: one key byte per transfer
          if (!ovalid_r || out_tready) begin
            ovalid_r <= 1'b1;
            key_r    <= out_byte;
            last_r   <= (n_r + 7'd1 == klen_r);
            stat_r   <= STATUS_OK;
            n_r      <= n_r + 7'd1;
            if (n_r + 7'd1 == klen_r) begin
              pw_cnt_r <= '0; salt_cnt_r <= '0; ovf_r <= 2'b00;
              state_r <= S_LOAD;
            end else if (j_r == 5'd19) begin
              blk_r <= blk_r + 3'd1;
              iter_left_r <= iter_r;
              first_r <= 1'b1;
              step_r  <= '0;
              state_r <= S_HMAC;
            end else j_r <= j_r + 5'd1;
          end
        end
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    (ovalid_r && !out_tready) |=> ovalid_r && $stable(key_r))
    else $error("output lost under stall");
  assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EMIT |-> n_r < klen_r)
    else $error("emitted past key length");
  assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> state_r == S_LOAD)
    else $error("input taken while busy");
endmodule

/* rtl/pbkdf2_hmac_sha1_engine_top.sv */
// PBKDF2 HMAC-SHA1 engine top level: controller plus datapath.
// Depends on pbkdf_pkg, pbkdf_ctrl, pbkdf_datapath, pbkdf_ram.
// Password and salt bytes are taken one per cycle while idle with no output
// pending. Each SHA-1 compression is issued, fills, runs 80 rounds and adds;
// a block takes 4 * iterations compressions, plus one when salt >= 52 bytes,
// for ceil(klen/20) blocks; its bytes leave one per cycle unless stalled.
// Reset (rst_n, synchronous, active low) clears counts and flags, loads the
// register defaults (iterations 1, key length 20) and empties the output.
`timescale 1ns / 1ps
module pbkdf2_hmac_sha1_engine_top
  import pbkdf_pkg::*;
#(
  parameter int KEY_MAX        = 64,
  parameter int ITERATION_BITS = 24
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [1:0]  in_tuser,   // mode
  input  logic [7:0]  in_tdata,   // data_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // key_byte[7:0], status[9:8], zero fill
  output logic        out_tlast,  // last
  input  logic        cfg_we,
  input  logic [0:0]  cfg_idx,
  input  logic [23:0] cfg_wdata
);
  logic        pw_we, salt_we;
  logic [5:0]  pw_waddr;
  logic [$clog2(SALT_MAX)-1:0] salt_waddr;
  logic [6:0]  pw_count;
  logic [$clog2(SALT_MAX+1)-1:0] salt_count;
  logic [2:0]  block_num;
  pbkdf_cmd_t  cmd;
  pbkdf_sts_t  sts;
  logic [4:0]  out_sel;
  logic [7:0]  out_byte, key;
  logic [1:0]  status;

  pbkdf_ctrl #(.KEY_MAX(KEY_MAX), .ITERATION_BITS(ITERATION_BITS)) u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_mode(in_tuser), .in_byte(in_tdata), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
    .cfg_wdata(cfg_wdata), .pw_we(pw_we), .pw_waddr(pw_waddr),
    .salt_we(salt_we), .salt_waddr(salt_waddr), .pw_count(pw_count),
    .salt_count(salt_count), .block_num(block_num), .cmd(cmd), .sts(sts),
    .out_sel(out_sel), .out_byte(out_byte), .out_tvalid(out_tvalid),
    .out_tready(out_tready), .out_key(key), .out_last(out_tlast),
    .out_status(status));

  pbkdf_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .pw_we(pw_we), .pw_waddr(pw_waddr),
    .salt_we(salt_we), .salt_waddr(salt_waddr), .wbyte(in_tdata),
    .pw_count(pw_count), .salt_count(salt_count), .block_num(block_num),
    .cmd(cmd), .sts(sts), .out_sel(out_sel), .out_byte(out_byte));

  assign out_tdata = {6'd0, status, key};
endmodule
